@@ design/drsf_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// drsf_pkg
// Shared types and constants of the display region SPI framer.
// ---------------------------------------------------------------------------
package drsf_pkg;

	// Command bytes
	localparam logic [7:0] MEM_WRITE_CMD = 8'h2C;
	localparam logic [7:0] DEF_ROW_CMD   = 8'h2A;
	localparam logic [7:0] DEF_COL_CMD   = 8'h2B;
	localparam logic [7:0] DUMMY_BYTE    = 8'h00;

	// Configuration register indexes
	localparam logic [2:0] REG_REGION_X      = 3'd0;
	localparam logic [2:0] REG_REGION_Y      = 3'd1;
	localparam logic [2:0] REG_REGION_WIDTH  = 3'd2;
	localparam logic [2:0] REG_REGION_HEIGHT = 3'd3;
	localparam logic [2:0] REG_PIX_FMT       = 3'd4;
	localparam logic [2:0] REG_DUMMY_COUNT   = 3'd5;
	localparam logic [2:0] REG_ROW_COMMAND   = 3'd6;
	localparam logic [2:0] REG_COL_COMMAND   = 3'd7;

	// Pixel format codes
	localparam logic [2:0] PF_1BPP   = 3'd0;
	localparam logic [2:0] PF_8BPP   = 3'd1;
	localparam logic [2:0] PF_RGB565 = 3'd2;
	localparam logic [2:0] PF_RGB888 = 3'd3;

	// Row byte count: up to 65536 pixels times three bytes
	localparam int TOT_W = 18;

	// Last 1bpp bit position in a byte
	localparam logic [2:0] PACK_LAST = 3'd7;

	// One accepted request, as handed from the row control to the emitter
	typedef struct packed {
		logic        hdr;
		logic [15:0] row_addr;
		logic        data_valid;
		logic [7:0]  data;
		logic        dc_level;
		logic        frame_end;
		logic        done;
		logic        err;
	} drsf_item_t;

	// Header settings with defaults already resolved
	typedef struct packed {
		logic [15:0] col_addr;
		logic [3:0]  dummies;
		logic [7:0]  row_cmd;
		logic [7:0]  col_cmd;
	} drsf_hdr_cfg_t;

	typedef enum logic [10:0] {
		PH_ROW_CMD = 11'b000_0000_0001,
		PH_ROW_DUM = 11'b000_0000_0010,
		PH_ROW_HI  = 11'b000_0000_0100,
		PH_ROW_LO  = 11'b000_0000_1000,
		PH_COL_CMD = 11'b000_0001_0000,
		PH_COL_DUM = 11'b000_0010_0000,
		PH_COL_HI  = 11'b000_0100_0000,
		PH_COL_LO  = 11'b000_1000_0000,
		PH_WR_CMD  = 11'b001_0000_0000,
		PH_WR_DUM  = 11'b010_0000_0000,
		PH_DATA    = 11'b100_0000_0000
	} drsf_phase_t;

endpackage
`default_nettype wire

@@ design/drsf_row_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// drsf_row_ctrl
// Row and pixel-pack bookkeeping; builds the descriptor of each request.
// ---------------------------------------------------------------------------
module drsf_row_ctrl #(
	parameter int LINE_BYTES = 512
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  wire  [7:0]           source_byte,
	input  wire  [15:0]          region_y,
	input  wire  [15:0]          region_width,
	input  wire  [15:0]          region_height,
	input  wire  [2:0]           pix_fmt,
	output drsf_pkg::drsf_item_t item,
	output logic                 has_result
);

	localparam int BW = $clog2(LINE_BYTES);

	logic [15:0]  row_index_q;
	logic [BW-1:0] byte_in_row_q;
	logic [7:0]   pack_bits_q;
	logic [2:0]   pack_count_q;

	logic [16:0]  w, h;
	logic [drsf_pkg::TOT_W-1:0] w_ext, total;
	logic         line_err, row_start, last_in_row, last_row, one_bit;
	logic [7:0]   pk_base, pk_new;
	logic [2:0]   cnt_base;
	logic         pk_emit;

	always_comb begin
		w = (region_width == 16'd0) ? 17'h10000 : {1'b0, region_width};
		h = (region_height == 16'd0) ? 17'h10000 : {1'b0, region_height};
		w_ext = drsf_pkg::TOT_W'(w);
		case (pix_fmt)
			drsf_pkg::PF_1BPP, drsf_pkg::PF_8BPP: total = w_ext;
			drsf_pkg::PF_RGB888:                  total = w_ext + (w_ext << 1);
			default:                              total = w_ext << 1;
		endcase
		line_err    = total > drsf_pkg::TOT_W'(LINE_BYTES);
		row_start   = (byte_in_row_q == '0);
		last_in_row = (drsf_pkg::TOT_W'(byte_in_row_q) + drsf_pkg::TOT_W'(1)) >= total;
		last_row    = ({1'b0, row_index_q} + 17'd1) >= h;
		one_bit     = (pix_fmt == drsf_pkg::PF_1BPP);

		// other formats drop pending pixels at a row start
		pk_base  = (row_start && !one_bit) ? 8'd0 : pack_bits_q;
		cnt_base = (row_start && !one_bit) ? 3'd0 : pack_count_q;
		pk_new   = pk_base | ((source_byte != 8'd0) ? (8'h80 >> pack_count_q) : 8'd0);
		pk_emit  = (pack_count_q == drsf_pkg::PACK_LAST) || last_in_row;

		if (line_err) begin
			item.hdr        = 1'b0;
			item.row_addr   = '0;
			item.data_valid = 1'b1;
			item.data       = 8'd0;
			item.dc_level   = 1'b0;
			item.frame_end  = 1'b0;
			item.done       = 1'b0;
			item.err        = 1'b1;
		end else begin
			item.hdr        = row_start;
			item.row_addr   = region_y + row_index_q;
			item.data_valid = !one_bit || pk_emit;
			item.data       = one_bit ? pk_new : source_byte;
			item.dc_level   = 1'b1;
			item.frame_end  = last_in_row;
			item.done       = last_in_row && last_row;
			item.err        = 1'b0;
		end
		has_result = item.hdr || item.data_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_index_q   <= '0;
			byte_in_row_q <= '0;
			pack_bits_q   <= '0;
			pack_count_q  <= '0;
		end else if (accept && !line_err) begin
			if (one_bit) begin
				if (pk_emit) begin
					pack_bits_q  <= 8'd0;
					pack_count_q <= 3'd0;
				end else begin
					pack_bits_q  <= pk_new;
					pack_count_q <= pack_count_q + 3'd1;
				end
			end else begin
				pack_bits_q  <= pk_base;
				pack_count_q <= cnt_base;
			end
			if (last_in_row) begin
				byte_in_row_q <= '0;
				row_index_q   <= last_row ? 16'd0 : row_index_q + 16'd1;
			end else begin
				byte_in_row_q <= byte_in_row_q + BW'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ design/drsf_emitter.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// drsf_emitter
// Walks the row header and the data byte of one request into the output
// register.
// ---------------------------------------------------------------------------
module drsf_emitter (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     load,
	input  drsf_pkg::drsf_item_t    item,
	input  drsf_pkg::drsf_hdr_cfg_t hcfg,
	output logic                    slot_free,
	output logic                    out_valid,
	input  wire                     out_ready,
	output logic [7:0]              spi_byte,
	output logic                    dc_level,
	output logic                    frame_end,
	output logic                    last_of_item,
	output logic                    region_done,
	output logic                    error
);

	drsf_pkg::drsf_item_t  item_s1;
	logic                  valid_s1;
	drsf_pkg::drsf_phase_t phase_q, phase_nxt;
	logic [3:0]            cnt_q;

	logic       step, is_last, last_dum, dum_phase;
	logic [7:0] byte_c;
	logic       dc_c, fe_c, done_c, err_c;

	always_comb begin
		step      = valid_s1 && (!out_valid || out_ready);
		last_dum  = (cnt_q == hcfg.dummies - 4'd1);
		dum_phase = 1'b0;
		byte_c    = drsf_pkg::DUMMY_BYTE;
		dc_c      = 1'b0;
		fe_c      = 1'b1;
		done_c    = 1'b0;
		err_c     = 1'b0;
		phase_nxt = phase_q;
		unique case (phase_q)
			drsf_pkg::PH_ROW_CMD: begin
				byte_c    = hcfg.row_cmd;
				phase_nxt = drsf_pkg::PH_ROW_DUM;
			end
			drsf_pkg::PH_ROW_DUM: begin
				dum_phase = 1'b1;
				if (last_dum)
					phase_nxt = drsf_pkg::PH_ROW_HI;
			end
			drsf_pkg::PH_ROW_HI: begin
				byte_c    = item_s1.row_addr[15:8];
				phase_nxt = drsf_pkg::PH_ROW_LO;
			end
			drsf_pkg::PH_ROW_LO: begin
				byte_c    = item_s1.row_addr[7:0];
				phase_nxt = drsf_pkg::PH_COL_CMD;
			end
			drsf_pkg::PH_COL_CMD: begin
				byte_c    = hcfg.col_cmd;
				phase_nxt = drsf_pkg::PH_COL_DUM;
			end
			drsf_pkg::PH_COL_DUM: begin
				dum_phase = 1'b1;
				if (last_dum)
					phase_nxt = drsf_pkg::PH_COL_HI;
			end
			drsf_pkg::PH_COL_HI: begin
				byte_c    = hcfg.col_addr[15:8];
				phase_nxt = drsf_pkg::PH_COL_LO;
			end
			drsf_pkg::PH_COL_LO: begin
				byte_c    = hcfg.col_addr[7:0];
				phase_nxt = drsf_pkg::PH_WR_CMD;
			end
			drsf_pkg::PH_WR_CMD: begin
				byte_c    = drsf_pkg::MEM_WRITE_CMD;
				phase_nxt = drsf_pkg::PH_WR_DUM;
			end
			drsf_pkg::PH_WR_DUM: begin
				dum_phase = 1'b1;
				if (last_dum)
					phase_nxt = drsf_pkg::PH_DATA;
			end
			drsf_pkg::PH_DATA: begin
				byte_c = item_s1.data;
				dc_c   = item_s1.dc_level;
				fe_c   = item_s1.frame_end;
				done_c = item_s1.done;
				err_c  = item_s1.err;
			end
			default: phase_nxt = drsf_pkg::PH_DATA;
		endcase
		// a header with no data byte ends on its last dummy
		is_last = (phase_q == drsf_pkg::PH_DATA) ||
			((phase_q == drsf_pkg::PH_WR_DUM) && last_dum && !item_s1.data_valid);
		slot_free = !valid_s1 || (step && is_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= drsf_pkg::PH_DATA;
			cnt_q    <= '0;
		end else if (load) begin
			valid_s1 <= 1'b1;
			phase_q  <= item.hdr ? drsf_pkg::PH_ROW_CMD : drsf_pkg::PH_DATA;
			cnt_q    <= '0;
		end else if (step) begin
			if (is_last)
				valid_s1 <= 1'b0;
			phase_q <= phase_nxt;
			cnt_q   <= (dum_phase && !last_dum) ? cnt_q + 4'd1 : 4'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			item_s1 <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (step)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			spi_byte     <= byte_c;
			dc_level     <= dc_c;
			frame_end    <= fe_c;
			last_of_item <= is_last;
			region_done  <= done_c;
			error        <= err_c;
		end
	end

endmodule
`default_nettype wire

@@ design/display_region_spi_framer.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// display_region_spi_framer
// Turns the source bytes of a display region into framed SPI bytes.
// ---------------------------------------------------------------------------
// Usage:
//   Source bytes enter on in_valid/in_ready, row by row. SPI bytes leave on
//   out_valid/out_ready with their data/command flag, frame end, last-of-
//   request, region-done and error flags. Registers are written through
//   cfg_write/cfg_index/cfg_data while the block is idle.
//   The first byte of each row expands into a header: row command, dummies,
//   row address, column command, dummies, column address, 0x2C, dummies
//   (7 + 3*dummies bytes, dummies of 0 count as 1), each in its own frame.
//   Row bytes follow in one data frame; 1bpp pixels are packed MSB-first.
//   A taken request is held in the request register; its bytes then leave
//   through the output register. Throughput: one data byte per cycle while
//   out_ready is high; a row start holds the input while its header bytes
//   go through the single output register the header sequencer feeds.
//   While out_ready is low the output register holds; one more request is
//   taken and parked in the request register, then in_ready drops.
//   Reset clears the row/pack counters and loads the register defaults.
// ---------------------------------------------------------------------------
module display_region_spi_framer #(
	parameter int LINE_BYTES = 512
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  source_byte,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [7:0]  spi_byte,
	output logic        dc_level,
	output logic        frame_end,
	output logic        last_of_item,
	output logic        region_done,
	output logic        error,
	input  wire         cfg_write,
	input  wire  [2:0]  cfg_index,
	input  wire  [15:0] cfg_data
);

	logic [15:0] region_x_q, region_y_q, region_width_q, region_height_q;
	logic [2:0]  pix_fmt_q;
	logic [3:0]  dummy_count_q;
	logic [7:0]  row_command_q, column_command_q;

	drsf_pkg::drsf_item_t    item;
	drsf_pkg::drsf_hdr_cfg_t hcfg;
	logic                    has_result, accept, slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_x_q       <= 16'd0;
			region_y_q       <= 16'd0;
			region_width_q   <= 16'd1;
			region_height_q  <= 16'd1;
			pix_fmt_q        <= drsf_pkg::PF_RGB565;
			dummy_count_q    <= 4'd1;
			row_command_q    <= drsf_pkg::DEF_ROW_CMD;
			column_command_q <= drsf_pkg::DEF_COL_CMD;
		end else if (cfg_write) begin
			unique case (cfg_index)
				drsf_pkg::REG_REGION_X:      region_x_q       <= cfg_data;
				drsf_pkg::REG_REGION_Y:      region_y_q       <= cfg_data;
				drsf_pkg::REG_REGION_WIDTH:  region_width_q   <= cfg_data;
				drsf_pkg::REG_REGION_HEIGHT: region_height_q  <= cfg_data;
				drsf_pkg::REG_PIX_FMT:       pix_fmt_q        <= cfg_data[2:0];
				drsf_pkg::REG_DUMMY_COUNT:   dummy_count_q    <= cfg_data[3:0];
				drsf_pkg::REG_ROW_COMMAND:   row_command_q    <= cfg_data[7:0];
				drsf_pkg::REG_COL_COMMAND:   column_command_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		hcfg.col_addr = region_x_q;
		hcfg.dummies  = (dummy_count_q == 4'd0) ? 4'd1 : dummy_count_q;
		hcfg.row_cmd  = (row_command_q == 8'd0) ? drsf_pkg::DEF_ROW_CMD : row_command_q;
		hcfg.col_cmd  = (column_command_q == 8'd0) ? drsf_pkg::DEF_COL_CMD
			: column_command_q;
		in_ready      = slot_free;
		accept        = in_valid && slot_free;
	end

	drsf_row_ctrl #(
		.LINE_BYTES(LINE_BYTES)
	) u_row_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.source_byte  (source_byte),
		.region_y     (region_y_q),
		.region_width (region_width_q),
		.region_height(region_height_q),
		.pix_fmt      (pix_fmt_q),
		.item         (item),
		.has_result   (has_result)
	);

	drsf_emitter u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (accept && has_result),
		.item        (item),
		.hcfg        (hcfg),
		.slot_free   (slot_free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.spi_byte    (spi_byte),
		.dc_level    (dc_level),
		.frame_end   (frame_end),
		.last_of_item(last_of_item),
		.region_done (region_done),
		.error       (error)
	);

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking testbench of display_region_spi_framer. Source bytes go in
// through a valid/ready sender with random gaps; an in-bench model of the
// framer predicts every SPI byte and its flags, and a monitor compares each
// byte taken from the output, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module tb;

	localparam int LINE_BYTES  = 512;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 6;
	localparam int IDLE_PCT    = 23;

	typedef struct packed {
		logic [7:0] spi_byte;
		logic       dc_level;
		logic       frame_end;
		logic       last_of_item;
		logic       region_done;
		logic       error;
	} spi_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  source_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  spi_byte;
	logic        dc_level;
	logic        frame_end;
	logic        last_of_item;
	logic        region_done;
	logic        error;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [15:0] cfg_data = 16'h0000;

	display_region_spi_framer #(.LINE_BYTES(LINE_BYTES)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .source_byte(source_byte),
		.out_valid(out_valid), .out_ready(out_ready), .spi_byte(spi_byte),
		.dc_level(dc_level), .frame_end(frame_end), .last_of_item(last_of_item),
		.region_done(region_done), .error(error),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Model copy of the registers and the row/pack counters
	logic [15:0] m_x, m_y, m_w, m_h;
	logic [2:0]  m_fmt;
	logic [3:0]  m_dummies;
	logic [7:0]  m_row_cmd, m_col_cmd;
	logic [15:0] row_idx, byte_cnt;
	logic [7:0]  pack_bits;
	logic [2:0]  pack_cnt;

	spi_res_t spi_expect_q[$];
	spi_res_t burst_q[$];

	int  mismatch_cnt = 0;
	int  cycle_cnt = 0;
	int  items_sent = 0;
	bit  steady = 1'b0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_cnt, msg);
		mismatch_cnt++;
	endtask

	function automatic int px_bytes(input logic [2:0] fmt);
		case (fmt)
			drsf_pkg::PF_1BPP, drsf_pkg::PF_8BPP: return 1;
			drsf_pkg::PF_RGB565:                  return 2;
			drsf_pkg::PF_RGB888:                  return 3;
			default:                              return 2;
		endcase
	endfunction

	function automatic int row_bytes();
		int w;
		w = (m_w == 16'd0) ? 65536 : int'(m_w);
		return w * px_bytes(m_fmt);
	endfunction

	task automatic reset_model();
		m_x = 16'd0;
		m_y = 16'd0;
		m_w = 16'd1;
		m_h = 16'd1;
		m_fmt = drsf_pkg::PF_RGB565;
		m_dummies = 4'd1;
		m_row_cmd = drsf_pkg::DEF_ROW_CMD;
		m_col_cmd = drsf_pkg::DEF_COL_CMD;
		row_idx = 16'd0;
		byte_cnt = 16'd0;
		pack_bits = 8'd0;
		pack_cnt = 3'd0;
	endtask

	task automatic apply_cfg(input logic [2:0] idx, input logic [15:0] data);
		case (idx)
			drsf_pkg::REG_REGION_X:      m_x = data;
			drsf_pkg::REG_REGION_Y:      m_y = data;
			drsf_pkg::REG_REGION_WIDTH:  m_w = data;
			drsf_pkg::REG_REGION_HEIGHT: m_h = data;
			drsf_pkg::REG_PIX_FMT:       m_fmt = data[2:0];
			drsf_pkg::REG_DUMMY_COUNT:   m_dummies = data[3:0];
			drsf_pkg::REG_ROW_COMMAND:   m_row_cmd = data[7:0];
			drsf_pkg::REG_COL_COMMAND:   m_col_cmd = data[7:0];
			default: ;
		endcase
	endtask

	task automatic push_res(input logic [7:0] b, input logic dm, input logic fe,
		input logic done, input logic err);
		spi_res_t r;
		r.spi_byte = b;
		r.dc_level = dm;
		r.frame_end = fe;
		r.last_of_item = 1'b0;
		r.region_done = done;
		r.error = err;
		burst_q.push_back(r);
	endtask

	task automatic push_cmd(input logic [7:0] b);
		push_res(b, 1'b0, 1'b1, 1'b0, 1'b0);
	endtask

	task automatic push_dummies();
		int n;
		n = (m_dummies == 4'd0) ? 1 : int'(m_dummies);
		repeat (n) push_cmd(drsf_pkg::DUMMY_BYTE);
	endtask

	task automatic push_addr(input logic [15:0] a);
		push_cmd(a[15:8]);
		push_cmd(a[7:0]);
	endtask

	// Expected SPI bytes for one accepted source byte
	task automatic predict_spi_bytes(input logic [7:0] src);
		int total, h, pos;
		logic last_in_row, last_row, done;
		logic [15:0] addr;
		spi_res_t r;
		burst_q.delete();
		total = row_bytes();
		h = (m_h == 16'd0) ? 65536 : int'(m_h);
		if (total > LINE_BYTES) begin
			push_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
		end else begin
			if (byte_cnt == 16'd0) begin
				if (m_fmt != drsf_pkg::PF_1BPP) begin
					pack_bits = 8'd0;
					pack_cnt = 3'd0;
				end
				addr = m_y + row_idx;
				push_cmd((m_row_cmd == 8'd0) ? drsf_pkg::DEF_ROW_CMD : m_row_cmd);
				push_dummies();
				push_addr(addr);
				push_cmd((m_col_cmd == 8'd0) ? drsf_pkg::DEF_COL_CMD : m_col_cmd);
				push_dummies();
				push_addr(m_x);
				push_cmd(drsf_pkg::MEM_WRITE_CMD);
				push_dummies();
			end
			last_in_row = (int'(byte_cnt) + 1 >= total);
			last_row = (int'(row_idx) + 1 >= h);
			done = last_in_row && last_row;
			if (m_fmt == drsf_pkg::PF_1BPP) begin
				pos = int'(pack_cnt);
				if (src != 8'd0)
					pack_bits = pack_bits | (8'h80 >> pos);
				pos++;
				if (pos == 8 || last_in_row) begin
					push_res(pack_bits, 1'b1, last_in_row, done, 1'b0);
					pack_bits = 8'd0;
					pack_cnt = 3'd0;
				end else begin
					pack_cnt = pos[2:0];
				end
			end else begin
				push_res(src, 1'b1, last_in_row, done, 1'b0);
			end
			if (last_in_row) begin
				byte_cnt = 16'd0;
				row_idx = last_row ? 16'd0 : row_idx + 16'd1;
			end else begin
				byte_cnt = byte_cnt + 16'd1;
			end
		end
		if (burst_q.size() > 0) begin
			r = burst_q[burst_q.size() - 1];
			r.last_of_item = 1'b1;
			burst_q[burst_q.size() - 1] = r;
		end
		foreach (burst_q[i])
			spi_expect_q.push_back(burst_q[i]);
	endtask

	// Sender: in_valid stays up from one request to the next unless an idle
	// cycle is drawn in between
	task automatic send_byte(input logic [7:0] b);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		source_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_spi_bytes(b);
		items_sent++;
	endtask

	// Hold off input until every expected byte is out and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (spi_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [15:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		apply_cfg(idx, data);
	endtask

	always @(posedge clk)
		out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin : spi_check
		spi_res_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = {spi_byte, dc_level, frame_end, last_of_item, region_done, error};
			if (spi_expect_q.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h", got.spi_byte));
			end else begin
				want = spi_expect_q.pop_front();
				if (got.spi_byte != want.spi_byte)
					report_mismatch($sformatf("spi_byte %02h, want %02h",
						got.spi_byte, want.spi_byte));
				if (got.dc_level != want.dc_level)
					report_mismatch($sformatf("dc_level %0b, want %0b",
						got.dc_level, want.dc_level));
				if (got.frame_end != want.frame_end)
					report_mismatch($sformatf("frame_end %0b, want %0b",
						got.frame_end, want.frame_end));
				if (got.last_of_item != want.last_of_item)
					report_mismatch($sformatf("last_of_item %0b, want %0b",
						got.last_of_item, want.last_of_item));
				if (got.region_done != want.region_done)
					report_mismatch($sformatf("region_done %0b, want %0b",
						got.region_done, want.region_done));
				if (got.error != want.error)
					report_mismatch($sformatf("error %0b, want %0b",
						got.error, want.error));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Register defaults: two-byte pixel, one row of one pixel
	task automatic test_reset_defaults();
		send_byte(8'h00);
		send_byte(8'hFF);
	endtask

	// Header fields: address extremes with row address wrap, dummy extremes,
	// zero commands falling back to defaults
	task automatic test_header_fields();
		drain();
		set_reg(drsf_pkg::REG_REGION_X, 16'hFFFF);
		set_reg(drsf_pkg::REG_REGION_Y, 16'hFFFF);
		set_reg(drsf_pkg::REG_REGION_WIDTH, 16'd2);
		set_reg(drsf_pkg::REG_REGION_HEIGHT, 16'd2);
		set_reg(drsf_pkg::REG_PIX_FMT, {13'd0, drsf_pkg::PF_8BPP});
		set_reg(drsf_pkg::REG_DUMMY_COUNT, 16'd15);
		set_reg(drsf_pkg::REG_ROW_COMMAND, 16'd0);
		set_reg(drsf_pkg::REG_COL_COMMAND, 16'd0);
		send_byte(8'hA5);
		send_byte(8'h5A);
		send_byte(8'h01);
		send_byte(8'h80);
		drain();
		set_reg(drsf_pkg::REG_DUMMY_COUNT, 16'd0);
		set_reg(drsf_pkg::REG_ROW_COMMAND, 16'h00FF);
		set_reg(drsf_pkg::REG_COL_COMMAND, 16'h0001);
		set_reg(drsf_pkg::REG_REGION_X, 16'h0000);
		set_reg(drsf_pkg::REG_REGION_WIDTH, 16'd1);
		set_reg(drsf_pkg::REG_REGION_HEIGHT, 16'd1);
		send_byte(8'h3C);
	endtask

	// 1bpp: one full byte, then a padded tail
	task automatic test_one_bit_packing();
		drain();
		set_reg(drsf_pkg::REG_PIX_FMT, {13'd0, drsf_pkg::PF_1BPP});
		set_reg(drsf_pkg::REG_REGION_WIDTH, 16'd10);
		set_reg(drsf_pkg::REG_DUMMY_COUNT, 16'd1);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h80);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h7F);
		send_byte(8'h00);
	endtask

	// Row byte count around the line capacity, zero width included
	task automatic test_line_limit();
		drain();
		set_reg(drsf_pkg::REG_PIX_FMT, {13'd0, drsf_pkg::PF_RGB888});
		set_reg(drsf_pkg::REG_REGION_WIDTH, 16'd171);
		send_byte(8'h12);
		drain();
		set_reg(drsf_pkg::REG_REGION_WIDTH, 16'd0);
		send_byte(8'h34);
		drain();
		set_reg(drsf_pkg::REG_PIX_FMT, {13'd0, drsf_pkg::PF_8BPP});
		set_reg(drsf_pkg::REG_REGION_WIDTH, 16'd513);
		send_byte(8'h56);
		drain();
		set_reg(drsf_pkg::REG_PIX_FMT, 16'd6);
		set_reg(drsf_pkg::REG_REGION_WIDTH, 16'd257);
		send_byte(8'h78);
		drain();
		set_reg(drsf_pkg::REG_PIX_FMT, {13'd0, drsf_pkg::PF_RGB888});
		set_reg(drsf_pkg::REG_REGION_WIDTH, 16'd170);
		send_byte(8'h9A);
		send_byte(8'hBC);
	endtask

	// Changes inside a region: shrunk width ends the row, 1bpp bits survive a
	// width change but not a format change
	task automatic test_mid_region_change();
		drain();
		set_reg(drsf_pkg::REG_REGION_WIDTH, 16'd1);
		send_byte(8'hDE);
		drain();
		set_reg(drsf_pkg::REG_PIX_FMT, {13'd0, drsf_pkg::PF_1BPP});
		set_reg(drsf_pkg::REG_REGION_WIDTH, 16'd8);
		set_reg(drsf_pkg::REG_REGION_HEIGHT, 16'd2);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h01);
		drain();
		set_reg(drsf_pkg::REG_REGION_WIDTH, 16'd2);
		send_byte(8'h00);
		send_byte(8'h80);
		drain();
		set_reg(drsf_pkg::REG_PIX_FMT, {13'd0, drsf_pkg::PF_8BPP});
		send_byte(8'h11);
		send_byte(8'h22);
	endtask

	function automatic logic [15:0] pick_addr(input bit near_wrap);
		int r;
		r = $urandom_range(99);
		if (r < 20)
			return 16'h0000;
		if (r < 40)
			return near_wrap ? 16'hFFFF - 16'($urandom_range(2)) : 16'hFFFF;
		return 16'($urandom);
	endfunction

	task automatic test_random_regions(input int goal);
		int phase, r, w, h, bpp, total, rows, plan, stop_at;
		logic [2:0] fmt;
		logic [7:0] src;
		phase = 0;
		stop_at = items_sent + goal;
		while (items_sent < stop_at) begin
			drain();
			steady = (phase >= 4 && phase < 8);
			fmt = 3'($urandom_range(7));
			bpp = px_bytes(fmt);
			r = $urandom_range(99);
			if (r < 6)
				w = ($urandom_range(1) == 0) ? 0 : $urandom_range(600, 65535);
			else if (r < 12)
				w = $urandom_range(LINE_BYTES / bpp - 3, LINE_BYTES / bpp);
			else
				w = $urandom_range(1, 9);
			r = $urandom_range(99);
			if (r < 5)
				h = 0;
			else if (r < 10)
				h = 65535;
			else
				h = $urandom_range(1, 4);
			set_reg(drsf_pkg::REG_REGION_X, pick_addr(1'b0));
			set_reg(drsf_pkg::REG_REGION_Y, pick_addr(1'b1));
			set_reg(drsf_pkg::REG_REGION_WIDTH, 16'(w));
			set_reg(drsf_pkg::REG_REGION_HEIGHT, 16'(h));
			set_reg(drsf_pkg::REG_PIX_FMT, {13'($urandom), fmt});
			set_reg(drsf_pkg::REG_DUMMY_COUNT, {12'($urandom), 4'($urandom_range(15))});
			set_reg(drsf_pkg::REG_ROW_COMMAND,
				{8'($urandom), ($urandom_range(99) < 15) ? 8'h00 : 8'($urandom)});
			set_reg(drsf_pkg::REG_COL_COMMAND,
				{8'($urandom), ($urandom_range(99) < 15) ? 8'h00 : 8'($urandom)});
			total = row_bytes();
			if (total > LINE_BYTES) begin
				plan = $urandom_range(1, 3);
			end else if (total > 24) begin
				// long rows are only entered, then cut by the next settings
				plan = $urandom_range(2, 12);
			end else begin
				rows = (h == 0 || h > 4) ? $urandom_range(1, 3) : h;
				plan = total * rows * $urandom_range(1, 2);
				if ($urandom_range(99) < 20)
					plan = $urandom_range(1, plan);
			end
			repeat (plan) begin
				if (fmt == drsf_pkg::PF_1BPP && $urandom_range(99) < 40)
					src = 8'h00;
				else
					src = 8'($urandom_range(255));
				send_byte(src);
			end
			phase++;
		end
		steady = 1'b0;
	endtask

	initial begin
		reset_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_header_fields();
		test_one_bit_packing();
		test_line_limit();
		test_mid_region_change();
		test_random_regions(330);
		drain();
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
